// File: rtl/core/heap_sort_keyed_records_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap sort block
// Concurrent property shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_KEYED_RECORDS_MACROS_SVH
`define HEAP_SORT_KEYED_RECORDS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSKR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hskr_pkg.sv
// ----------------------------------------------------------------------------
// hskr_pkg
// Shared constants, record type and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hskr_pkg;

  // Record store depth and field widths.
  localparam int CAPACITY = 64;
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 16;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = IDX_W + 2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } hskr_rec_t;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_BUILD_INIT = 4'd2;
  localparam logic [OP_W-1:0] OP_BUILD_RD   = 4'd3;
  localparam logic [OP_W-1:0] OP_BUILD_HOLD = 4'd4;
  localparam logic [OP_W-1:0] OP_SIFT_RD    = 4'd5;
  localparam logic [OP_W-1:0] OP_SIFT_CMP   = 4'd6;
  localparam logic [OP_W-1:0] OP_PUT        = 4'd7;
  localparam logic [OP_W-1:0] OP_SORT_INIT  = 4'd8;
  localparam logic [OP_W-1:0] OP_SORT_RD    = 4'd9;
  localparam logic [OP_W-1:0] OP_SORT_SWAP  = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT_INIT   = 4'd11;
  localparam logic [OP_W-1:0] OP_OUT_RD     = 4'd12;
  localparam logic [OP_W-1:0] OP_OUT_EMIT   = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } hskr_cmd_t;

  typedef struct packed {
    logic i_zero;     // loop counter is zero
    logic i_le1;      // loop counter is at most one
    logic leaf;       // current hole has no child inside the heap
    logic move;       // a child outranks the carried record
    logic emit_last;  // record being emitted is the final one
  } hskr_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/hskr_ctrl.sv
// ----------------------------------------------------------------------------
// hskr_ctrl
// Sequencer for loading, heap build, sort-down and emit phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hskr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               in_last_item,
  input  wire hskr_pkg::hskr_stat_t stat,
  output hskr_pkg::hskr_cmd_t     cmd,
  output logic                    busy
);
  import hskr_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_B_INIT = 4'd1;
  localparam logic [3:0] ST_B_CHK  = 4'd2;
  localparam logic [3:0] ST_B_HOLD = 4'd3;
  localparam logic [3:0] ST_S_RD   = 4'd4;
  localparam logic [3:0] ST_S_CMP  = 4'd5;
  localparam logic [3:0] ST_T_CHK  = 4'd6;
  localparam logic [3:0] ST_T_SWAP = 4'd7;
  localparam logic [3:0] ST_O_RD   = 4'd8;
  localparam logic [3:0] ST_O_EMIT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       sorting_r, sorting_nxt;  // sift returns to the sort-down loop
  logic [3:0] sift_ret;

  assign sift_ret = sorting_r ? ST_T_CHK : ST_B_CHK;
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    sorting_nxt = sorting_r;
    cmd.op      = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (in_last_item) begin
            state_nxt = ST_B_INIT;
          end
        end
      end
      ST_B_INIT: begin
        cmd.op    = OP_BUILD_INIT;
        state_nxt = ST_B_CHK;
      end
      ST_B_CHK: begin
        if (stat.i_zero) begin
          cmd.op    = OP_SORT_INIT;
          state_nxt = ST_T_CHK;
        end else begin
          cmd.op    = OP_BUILD_RD;
          state_nxt = ST_B_HOLD;
        end
      end
      ST_B_HOLD: begin
        cmd.op      = OP_BUILD_HOLD;
        sorting_nxt = 1'b0;
        state_nxt   = ST_S_RD;
      end
      ST_S_RD: begin
        if (stat.leaf) begin
          cmd.op    = OP_PUT;
          state_nxt = sift_ret;
        end else begin
          cmd.op    = OP_SIFT_RD;
          state_nxt = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        cmd.op    = OP_SIFT_CMP;
        state_nxt = stat.move ? ST_S_RD : sift_ret;
      end
      ST_T_CHK: begin
        if (stat.i_le1) begin
          cmd.op    = OP_OUT_INIT;
          state_nxt = ST_O_RD;
        end else begin
          cmd.op    = OP_SORT_RD;
          state_nxt = ST_T_SWAP;
        end
      end
      ST_T_SWAP: begin
        cmd.op      = OP_SORT_SWAP;
        sorting_nxt = 1'b1;
        state_nxt   = ST_S_RD;
      end
      ST_O_RD: begin
        cmd.op    = OP_OUT_RD;
        state_nxt = ST_O_EMIT;
      end
      ST_O_EMIT: begin
        cmd.op    = OP_OUT_EMIT;
        state_nxt = stat.emit_last ? ST_IDLE : ST_O_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      sorting_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sorting_r <= sorting_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hskr_dpath.sv
// ----------------------------------------------------------------------------
// hskr_dpath
// Record store, heap pointers, sift compare unit and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hskr_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire hskr_pkg::hskr_cmd_t        cmd,
  input  wire logic [hskr_pkg::KEY_W-1:0] in_key,
  input  wire logic [hskr_pkg::PAY_W-1:0] in_payload,
  output hskr_pkg::hskr_stat_t            stat,
  output logic                            out_valid,
  output logic [hskr_pkg::KEY_W-1:0]      out_sorted_key,
  output logic [hskr_pkg::PAY_W-1:0]      out_sorted_payload,
  output logic                            out_end_of_run,
  output logic                            out_overflowed
);
  import hskr_pkg::*;

  hskr_rec_t mem [CAPACITY];
  hskr_rec_t rd_a_r, rd_b_r;
  hskr_rec_t hold_r, hold_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;

  logic [KEY_W-1:0] okey_r;
  logic [PAY_W-1:0] opay_r;
  logic             oend_r, oovf_r, ovalid_r;

  logic             we;
  logic [IDX_W-1:0] waddr, addr_a, addr_b;
  hskr_rec_t        wdata;

  logic [CNT_W-1:0]   i_m1, k_p1;
  logic [CHILD_W-1:0] l_idx, r_idx;
  logic               r_in, pick_l, pick_r;
  logic [KEY_W-1:0]   top_key;
  hskr_rec_t          best;
  logic [IDX_W-1:0]   best_idx;
  logic               room;

  assign i_m1  = i_r - CNT_W'(1);
  assign k_p1  = CNT_W'(k_r) + CNT_W'(1);
  assign l_idx = CHILD_W'({pos_r, 1'b0}) + CHILD_W'(1);
  assign r_idx = CHILD_W'({pos_r, 1'b0}) + CHILD_W'(2);
  assign r_in  = (r_idx < CHILD_W'(len_r));
  assign room  = (count_r < CNT_W'(CAPACITY));

  // Carried record against left child, then the winner against the right.
  assign pick_l   = (rd_a_r.key > hold_r.key);
  assign top_key  = pick_l ? rd_a_r.key : hold_r.key;
  assign pick_r   = r_in && (rd_b_r.key > top_key);
  assign best     = pick_r ? rd_b_r : rd_a_r;
  assign best_idx = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

  assign stat.i_zero    = (i_r == '0);
  assign stat.i_le1     = (i_r <= CNT_W'(1));
  assign stat.leaf      = (l_idx >= CHILD_W'(len_r));
  assign stat.move      = pick_l || pick_r;
  assign stat.emit_last = (k_p1 == count_r);

  always_comb begin
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = hold_r;
    addr_a    = k_r;
    addr_b    = i_m1[IDX_W-1:0];
    hold_nxt  = hold_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    case (cmd.op)
      OP_LOAD: begin
        if (room) begin
          we        = 1'b1;
          waddr     = count_r[IDX_W-1:0];
          wdata     = '{key: in_key, payload: in_payload};
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_BUILD_INIT: begin
        i_nxt = count_r >> 1;
      end
      OP_BUILD_RD: begin
        addr_a = i_m1[IDX_W-1:0];
      end
      OP_BUILD_HOLD: begin
        hold_nxt = rd_a_r;
        pos_nxt  = i_m1[IDX_W-1:0];
        len_nxt  = count_r;
        i_nxt    = i_m1;
      end
      OP_SIFT_RD: begin
        addr_a = l_idx[IDX_W-1:0];
        addr_b = r_idx[IDX_W-1:0];
      end
      OP_SIFT_CMP: begin
        we = 1'b1;
        if (pick_l || pick_r) begin
          wdata   = best;
          pos_nxt = best_idx;
        end
      end
      OP_PUT: begin
        we = 1'b1;
      end
      OP_SORT_INIT: begin
        i_nxt = count_r;
      end
      OP_SORT_RD: begin
        addr_a = '0;
      end
      OP_SORT_SWAP: begin
        we       = 1'b1;
        waddr    = i_m1[IDX_W-1:0];
        wdata    = rd_a_r;
        hold_nxt = rd_b_r;
        pos_nxt  = '0;
        len_nxt  = i_m1;
        i_nxt    = i_m1;
      end
      OP_OUT_INIT: begin
        k_nxt = '0;
      end
      OP_OUT_RD: begin
        addr_a = k_r;
      end
      OP_OUT_EMIT: begin
        k_nxt = k_r + IDX_W'(1);
        if (k_p1 == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
    len_r  <= len_nxt;
    if (cmd.op == OP_OUT_EMIT) begin
      okey_r <= rd_a_r.key;
      opay_r <= rd_a_r.payload;
      oend_r <= (k_p1 == count_r);
      oovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= (cmd.op == OP_OUT_EMIT);
    end
  end

  assign out_valid          = ovalid_r;
  assign out_sorted_key     = okey_r;
  assign out_sorted_payload = opay_r;
  assign out_end_of_run     = oend_r;
  assign out_overflowed     = oovf_r;

endmodule

`default_nettype wire

// File: rtl/core/heap_sort_keyed_records.sv
// Loading: a record beat is taken whenever start is high and busy is low; after the last
// beat the heap build and sort-down run, each sift walking at most log2 of the count levels,
// and each sorted record is read from the store and then emitted.
// Throughput: one set at a time; busy stays high from the last beat until the final result.
// Results appear for one cycle each under out_valid and cannot be held off by the receiver.
// Reset (synchronous, active low) empties the set and clears the overflow flag.
// ----------------------------------------------------------------------------
// heap_sort_keyed_records
// Collects keyed records, heap sorts them by key and streams them out ascending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heap_sort_keyed_records (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [hskr_pkg::KEY_W-1:0] in_key,
  input  wire logic [hskr_pkg::PAY_W-1:0] in_payload,
  input  wire logic                       in_last_item,
  output logic                            out_valid,
  output logic [hskr_pkg::KEY_W-1:0]      out_sorted_key,
  output logic [hskr_pkg::PAY_W-1:0]      out_sorted_payload,
  output logic                            out_end_of_run,
  output logic                            out_overflowed
);
  import hskr_pkg::*;

  // The controller walks the classic heapsort loops. Each sift-down carries the
  // record that started at the root in a holding register and moves the larger
  // child up into the hole, which gives the same final order as repeated swaps.
  // The record store has one write port and two registered read ports, so one
  // sift level takes a read step (both children) and a compare/write step.
  hskr_cmd_t  cmd;
  hskr_stat_t stat;

  hskr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_item (in_last_item),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // Records beyond the store capacity are dropped during the load beat and the
  // overflow flag rides along on every result of that set.
  hskr_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_sorted_key     (out_sorted_key),
    .out_sorted_payload (out_sorted_payload),
    .out_end_of_run     (out_end_of_run),
    .out_overflowed     (out_overflowed)
  );

`include "heap_sort_keyed_records_macros.svh"

  // An accepted beat must always be turned into a store write or drop.
  `HSKR_ASSERT_SAME(a_accept_loads, start && !busy, cmd.op == OP_LOAD, "accepted beat not loaded")

  // The final result leaves the block idle; any earlier result finds it busy.
  `HSKR_ASSERT_SAME(a_end_vs_busy, out_valid, busy != out_end_of_run, "end of run and busy disagree")

  // Emitting a record is always followed by that record on the output.
  `HSKR_ASSERT_NEXT(a_emit_shows, cmd.op == OP_OUT_EMIT, out_valid, "emitted record not shown")

endmodule

`default_nettype wire

// File: tb/sv/heap_sort_keyed_records_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_keyed_records_tb
// Self-checking bench for the keyed-record heap sorter. It loads record sets
// of many sizes, including full and overfull sets, and ties on the key.
// Every sorted beat is checked against a predicted heap sort of the same set.
// ----------------------------------------------------------------------------

// One expected sorted beat, as the block should present it on the out_ ports.
typedef struct packed {
  logic [hskr_pkg::KEY_W-1:0] key;
  logic [hskr_pkg::PAY_W-1:0] payload;
  logic                       end_of_run;
  logic                       overflowed;
} sorted_beat_t;

// Scoreboard. It keeps its own copy of the record store and predicts the
// sorted beats that each closed set produces.
class heap_sort_predictor;
  hskr_pkg::hskr_rec_t held [hskr_pkg::CAPACITY];
  int unsigned         held_count;
  bit                  dropped_any;
  sorted_beat_t        expected_beats [$];
  int unsigned         mismatches;

  function new();
    held_count  = 0;
    dropped_any = 1'b0;
    mismatches  = 0;
  endfunction

  function int unsigned pending();
    return expected_beats.size();
  endfunction

  // Sift the record at root down a heap of len entries. Keys only, strict
  // greater-than, left child tried before the right one.
  function void sift_down(int unsigned len, int unsigned root);
    int unsigned         top;
    int unsigned         left_idx;
    int unsigned         right_idx;
    bit                  settled;
    hskr_pkg::hskr_rec_t spare;
    settled = 1'b0;
    while (!settled) begin
      top       = root;
      left_idx  = 2 * root + 1;
      right_idx = 2 * root + 2;
      if (left_idx < len && held[left_idx].key > held[top].key) top = left_idx;
      if (right_idx < len && held[right_idx].key > held[top].key) top = right_idx;
      if (top == root) begin
        settled = 1'b1;
      end else begin
        spare      = held[root];
        held[root] = held[top];
        held[top]  = spare;
        root       = top;
      end
    end
  endfunction

  // Note one accepted input beat. A beat with the last flag closes the set.
  function void take_record(logic [hskr_pkg::KEY_W-1:0] key,
                            logic [hskr_pkg::PAY_W-1:0] payload, logic last);
    hskr_pkg::hskr_rec_t spare;
    sorted_beat_t        beat;
    if (held_count < hskr_pkg::CAPACITY) begin
      held[held_count].key     = key;
      held[held_count].payload = payload;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      for (int i = held_count / 2; i > 0; i--) sift_down(held_count, i - 1);
      for (int i = held_count; i > 1; i--) begin
        spare       = held[0];
        held[0]     = held[i - 1];
        held[i - 1] = spare;
        sift_down(i - 1, 0);
      end
      for (int k = 0; k < held_count; k++) begin
        beat.key        = held[k].key;
        beat.payload    = held[k].payload;
        beat.end_of_run = (k + 1 == held_count);
        beat.overflowed = dropped_any;
        expected_beats  = {expected_beats, beat};
      end
      held_count  = 0;
      dropped_any = 1'b0;
    end
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Check one sorted beat against the oldest expectation.
  function void check_sorted_beat(sorted_beat_t got);
    sorted_beat_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t ns: sorted beat with none expected, expected nothing, actual %0h",
               $time, got);
      mismatches++;
      return;
    end
    want = expected_beats.pop_front();
    compare_field("sorted_key", 32'(want.key), 32'(got.key));
    compare_field("sorted_payload", 32'(want.payload), 32'(got.payload));
    compare_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
    compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
  endfunction
endclass

module heap_sort_keyed_records_tb;

  // How the keys of a generated set are spread.
  typedef enum int {
    KEYS_ANY,
    KEYS_CLASHING,
    KEYS_EXTREME
  } key_spread_t;

  typedef logic [hskr_pkg::KEY_W-1:0] key_field_t;
  typedef logic [hskr_pkg::PAY_W-1:0] pay_field_t;

  // Generous cycle limit. The slowest correct run is under two hundred item
  // beats plus the heap sorts of all its sets, each of up to 64 records.
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned RANDOM_ITEMS = 20;
  localparam int unsigned TAIL_CYCLES  = 50;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       start        = 1'b0;
  logic [hskr_pkg::KEY_W-1:0] in_key       = '0;
  logic [hskr_pkg::PAY_W-1:0] in_payload   = '0;
  logic                       in_last_item = 1'b0;
  logic                       busy;
  logic                       out_valid;
  logic [hskr_pkg::KEY_W-1:0] out_sorted_key;
  logic [hskr_pkg::PAY_W-1:0] out_sorted_payload;
  logic                       out_end_of_run;
  logic                       out_overflowed;

  heap_sort_predictor sorter_model = new();
  int unsigned        cycle_count  = 0;
  int unsigned        burst_left   = 0;
  int unsigned        random_sent  = 0;

  heap_sort_keyed_records u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_sorted_key     (out_sorted_key),
    .out_sorted_payload (out_sorted_payload),
    .out_end_of_run     (out_end_of_run),
    .out_overflowed     (out_overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hang anywhere in the run ends it here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[heap_sort_keyed_records] ERROR");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, while the block's
  // registers still hold their values from before the edge. An input beat
  // counts when start is high and busy is low; a sorted beat counts whenever
  // out_valid is high, since the receiver can never hold it off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start === 1'b1 && busy === 1'b0)
        sorter_model.take_record(in_key, in_payload, in_last_item);
      if (out_valid === 1'b1)
        sorter_model.check_sorted_beat({out_sorted_key, out_sorted_payload,
                                        out_end_of_run, out_overflowed});
    end
  end

  // Present one record at the falling edge and hold it until the block takes
  // it. Start is left high, so back-to-back beats need no gap.
  task automatic send_record(input logic [hskr_pkg::KEY_W-1:0] key,
                             input logic [hskr_pkg::PAY_W-1:0] payload,
                             input logic last);
    @(negedge clk);
    start        <= 1'b1;
    in_key       <= key;
    in_payload   <= payload;
    in_last_item <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Idle the sender for some cycles. The data ports carry junk meanwhile,
  // which the block must ignore because start is low.
  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      in_key       <= key_field_t'($urandom);
      in_payload   <= pay_field_t'($urandom);
      in_last_item <= 1'($urandom);
    end
  endtask

  // Hold off until every predicted sorted beat has arrived.
  task automatic wait_for_drain();
    while (sorter_model.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [hskr_pkg::KEY_W-1:0] pick_key(key_spread_t spread);
    logic [hskr_pkg::KEY_W-1:0] key;
    case (spread)
      KEYS_CLASHING: begin
        key = key_field_t'($urandom_range(0, 3));
      end
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = '1;
          2: key = {1'b1, {(hskr_pkg::KEY_W - 1){1'b0}}};
          default: key = {1'b0, {(hskr_pkg::KEY_W - 1){1'b1}}};
        endcase
      end
      default: begin
        key = key_field_t'($urandom);
      end
    endcase
    return key;
  endfunction

  // Send one whole set with random content. The sender runs in bursts with
  // random gaps; some bursts are long enough to give stretches of no idling.
  task automatic send_set(input int unsigned size, input key_spread_t spread);
    for (int unsigned i = 0; i < size; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      send_record(pick_key(spread), pay_field_t'($urandom), i + 1 == size);
    end
  endtask

  initial begin
    int unsigned set_size;
    int unsigned roll;
    key_spread_t spread;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets. A lone record at each extreme of both fields.
    send_record('0, '0, 1'b1);
    send_record('1, '1, 1'b1);
    // Three equal keys: the payload order shows the exact tie handling.
    send_record(16'h0005, 16'hAAAA, 1'b0);
    send_record(16'h0005, 16'h5555, 1'b0);
    send_record(16'h0005, 16'h0001, 1'b1);
    // Mixed extremes, arriving in no useful order.
    send_record(16'hFFFF, 16'h1234, 1'b0);
    send_record(16'h0000, 16'h8000, 1'b0);
    send_record(16'h8000, 16'h0001, 1'b0);
    send_record(16'h7FFF, 16'hFFFE, 1'b0);
    send_record(16'h0001, 16'h0000, 1'b1);
    // Already ascending, then a reversed pair.
    send_record(16'h0001, 16'h0101, 1'b0);
    send_record(16'h0002, 16'h0202, 1'b0);
    send_record(16'h0003, 16'h0303, 1'b0);
    send_record(16'h0004, 16'h0404, 1'b1);
    send_record(16'h0002, 16'h0022, 1'b0);
    send_record(16'h0001, 16'h0011, 1'b1);

    // The sender waits here until the block has emitted everything.
    pause_sender(1);
    wait_for_drain();

    // Capacity: exactly full, then one over so the final record itself is
    // dropped.
    send_set(hskr_pkg::CAPACITY, KEYS_ANY);
    send_set(hskr_pkg::CAPACITY + 1, KEYS_EXTREME);
    pause_sender(1);
    wait_for_drain();

    // Random small sets, some of a single record.
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll < 3)       set_size = 1;
      else                set_size = $urandom_range(2, 10);
      roll = $urandom_range(0, 9);
      if (roll < 6)       spread = KEYS_ANY;
      else if (roll < 9)  spread = KEYS_CLASHING;
      else                spread = KEYS_EXTREME;
      send_set(set_size, spread);
      random_sent += set_size;
      if ($urandom_range(0, 7) == 0) begin
        pause_sender(1);
        wait_for_drain();
      end
    end

    // Drop start, let the last set drain, then give the block a short tail
    // in which any stray beat would still be caught.
    pause_sender(1);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sorter_model.mismatches == 0 && sorter_model.pending() == 0) begin
      $display("[heap_sort_keyed_records] OK");
    end else begin
      $display("[heap_sort_keyed_records] ERROR");
    end
    $finish;
  end

endmodule
